### hw/rtl/pct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants for the PIN credential table.
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam int CODE_BYTES = 8;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = CODE_BYTES * BYTE_W;
    localparam int LEN_W      = 4;
    localparam int TIME_W     = 32;

    // stream payload widths
    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 16;
    localparam int COUNT_W    = 5;

    // APB
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam logic REG_CLOCK_PRESENT = 1'b0;  // word index bit paddr[2]

    localparam logic [LEN_W-1:0]  LEN_OVER = 4'd9;
    localparam logic [LEN_W-1:0]  LEN_MAXB = 4'd8;
    localparam logic [BYTE_W-1:0] DIGIT_LO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_HI = 8'h39;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_VALIDATE = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_NO_MATCH  = 3'd3,
        ST_WINDOW    = 3'd4
    } t_status;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              active;
        logic              limited;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_end;
    } t_entry;

    // normalized key from the code checker
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              malformed;
        logic              lookup_ok;
    } t_key;

    // compare unit result
    typedef struct packed {
        logic hit;
        logic window_fail;
    } t_cmp;

endpackage

### hw/rtl/pct_code_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_code_check
// Normalizes a code: effective length, masked bytes, digit and length checks.
// ----------------------------------------------------------------------------
module pct_code_check #(
    parameter int CODE_DIGITS = 8
) (
    input  logic [pct_pkg::CODE_W-1:0] i_chars,
    input  logic [pct_pkg::LEN_W-1:0]  i_length,
    output pct_pkg::t_key              o_key
);

    logic [pct_pkg::LEN_W-1:0]  lim;
    logic [pct_pkg::LEN_W-1:0]  eff;
    logic [pct_pkg::CODE_W-1:0] bits;
    logic                       digits;
    logic [pct_pkg::BYTE_W-1:0] ch;

    always_comb begin
        lim = (i_length > pct_pkg::LEN_MAXB) ? pct_pkg::LEN_MAXB : i_length;
        eff = (i_length > pct_pkg::LEN_MAXB) ? pct_pkg::LEN_OVER : i_length;
        // first zero byte terminates the code
        for (int i = pct_pkg::CODE_BYTES - 1; i >= 0; i--) begin
            if (pct_pkg::LEN_W'(i) < lim &&
                i_chars[i*pct_pkg::BYTE_W +: pct_pkg::BYTE_W] == '0) begin
                eff = pct_pkg::LEN_W'(i);
            end
        end
        bits   = '0;
        digits = 1'b1;
        ch     = '0;
        for (int i = 0; i < pct_pkg::CODE_BYTES; i++) begin
            if (pct_pkg::LEN_W'(i) < eff) begin
                ch = i_chars[i*pct_pkg::BYTE_W +: pct_pkg::BYTE_W];
                bits[i*pct_pkg::BYTE_W +: pct_pkg::BYTE_W] = ch;
                if (!(ch inside {[pct_pkg::DIGIT_LO:pct_pkg::DIGIT_HI]})) begin
                    digits = 1'b0;
                end
            end
        end
        o_key.bits      = bits;
        o_key.len       = eff;
        o_key.lookup_ok = (eff != '0) && (eff <= pct_pkg::LEN_W'(CODE_DIGITS));
        o_key.malformed = !o_key.lookup_ok || !digits;
    end

endmodule

### hw/rtl/pct_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_match_unit
// Shared compare unit: key vs. one table entry, plus time window check.
// ----------------------------------------------------------------------------
module pct_match_unit (
    input  pct_pkg::t_entry             i_entry,
    input  logic [pct_pkg::CODE_W-1:0]  i_key_bits,
    input  logic [pct_pkg::LEN_W-1:0]   i_key_len,
    input  logic                        i_need_active,
    input  logic [pct_pkg::TIME_W-1:0]  i_now,
    input  logic                        i_clock_present,
    output pct_pkg::t_cmp               o_cmp
);

    logic in_window;

    assign in_window = (i_now >= i_entry.t_start) && (i_now <= i_entry.t_end);

    assign o_cmp.hit = (i_entry.len == i_key_len) && (i_entry.code == i_key_bits) &&
                       (!i_need_active || i_entry.active);
    assign o_cmp.window_fail = i_entry.limited && i_clock_present && !in_window;

endmodule

### hw/rtl/pin_credential_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pin_credential_table
// Compacted table of PIN codes with active flag and optional time window.
// ----------------------------------------------------------------------------
// Usage:
//  - One command beat enters on s_axis (add/update, remove, validate, clear);
//    exactly one result beat leaves on m_axis (ok, status, entry_count).
//  - s_axis_tready is high only while the sequencer is idle; one item is in
//    flight at a time.
//  - Entries live in a single-port-read table memory and are visited one at a
//    time by a shared compare unit: each entry scanned takes a read state
//    and a compare state, and each entry moved down on remove takes a read
//    and a write state. Clear, full, malformed and empty or overlong lookups
//    are answered from the decide state without a scan; a hit ends the scan,
//    a miss or append scans all entries, and a remove that finds its entry
//    scans up to it and then shifts the entries above it down.
//  - The result is held in m_axis_tdata while m_axis_tvalid is high and
//    m_axis_tready low; the next command waits until the result is taken.
//  - Reset clears the entry count and the sequencer and sets clock_present
//    to 1; the table memory is not cleared (slots at or above the count
//    are never read). No clearing pass is needed.
//  - APB register 0 (byte address 0): bit 0 clock_present. Write only while
//    idle.
// ----------------------------------------------------------------------------
module pin_credential_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int CODE_DIGITS   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] cmd, [65:2] code_chars, [69:66] code_length, [70] is_active,
    // [71] has_time_limit, [103:72] valid_from, [135:104] valid_until,
    // [167:136] now_time
    input  logic [pct_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] ok, [3:1] status, [8:4] entry_count, [15:9] zero
    output logic [pct_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pct_pkg::APB_AW-1:0]    paddr,
    input  logic [pct_pkg::APB_DW-1:0]    pwdata,
    output logic [pct_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECIDE   = 7'b0000010,
        S_READ     = 7'b0000100,
        S_CMP      = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_RESP     = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] ptr_inc;
    logic r_ok, n_ok;
    pct_pkg::t_status r_status, n_status;
    logic r_clock_present;

    // captured command
    pct_pkg::t_cmd                r_cmd;
    logic [pct_pkg::CODE_W-1:0]   r_chars;
    logic [pct_pkg::LEN_W-1:0]    r_length;
    logic                         r_active;
    logic                         r_limited;
    logic [pct_pkg::TIME_W-1:0]   r_from;
    logic [pct_pkg::TIME_W-1:0]   r_until;
    logic [pct_pkg::TIME_W-1:0]   r_now;

    // table memory
    pct_pkg::t_entry r_mem [TABLE_ENTRIES];
    pct_pkg::t_entry r_rd_data;
    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    pct_pkg::t_entry mem_wdata;
    pct_pkg::t_entry add_entry;

    pct_pkg::t_key key;
    pct_pkg::t_cmp cmp;

    logic accept;
    logic cfg_wr;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_RESP);
    assign m_axis_tdata  = {{(pct_pkg::M_TDATA_W - 4 - pct_pkg::COUNT_W){1'b0}},
                            pct_pkg::COUNT_W'(r_count), r_status, r_ok};

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == pct_pkg::REG_CLOCK_PRESENT);
    assign prdata = (paddr[2] == pct_pkg::REG_CLOCK_PRESENT) ?
                    {{(pct_pkg::APB_DW-1){1'b0}}, r_clock_present} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_present <= 1'b1;
        end else if (cfg_wr) begin
            r_clock_present <= pwdata[0];
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= pct_pkg::t_cmd'(s_axis_tdata[1:0]);
            r_chars   <= s_axis_tdata[65:2];
            r_length  <= s_axis_tdata[69:66];
            r_active  <= s_axis_tdata[70];
            r_limited <= s_axis_tdata[71];
            r_from    <= s_axis_tdata[103:72];
            r_until   <= s_axis_tdata[135:104];
            r_now     <= s_axis_tdata[167:136];
        end
    end

    pct_code_check #(
        .CODE_DIGITS(CODE_DIGITS)
    ) u_code_check (
        .i_chars  (r_chars),
        .i_length (r_length),
        .o_key    (key)
    );

    pct_match_unit u_match (
        .i_entry         (r_rd_data),
        .i_key_bits      (key.bits),
        .i_key_len       (key.len),
        .i_need_active   (r_cmd == pct_pkg::CMD_VALIDATE),
        .i_now           (r_now),
        .i_clock_present (r_clock_present),
        .o_cmp           (cmp)
    );

    assign add_entry = '{code: key.bits, len: key.len, active: r_active,
                         limited: r_limited, t_start: r_from, t_end: r_until};
    assign ptr_inc   = r_ptr + CW'(1);

    // table memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_ok      = r_ok;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_ptr[AW-1:0];
        mem_raddr = r_ptr[AW-1:0];
        mem_wdata = add_entry;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_ptr    = '0;
                n_ok     = 1'b0;
                n_status = pct_pkg::ST_DONE;
                case (r_cmd)
                    pct_pkg::CMD_CLEAR: begin
                        n_count = '0;
                        n_ok    = 1'b1;
                        n_state = S_RESP;
                    end
                    pct_pkg::CMD_ADD: begin
                        // full table is refused even for an update
                        if (r_count >= CW'(TABLE_ENTRIES)) begin
                            n_status = pct_pkg::ST_FULL;
                            n_state  = S_RESP;
                        end else if (key.malformed) begin
                            n_status = pct_pkg::ST_MALFORMED;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        if (!key.lookup_ok) begin
                            n_status = pct_pkg::ST_NO_MATCH;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                endcase
            end
            S_READ: begin
                if (r_ptr >= r_count) begin
                    // scan exhausted
                    if (r_cmd == pct_pkg::CMD_ADD) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        n_ok    = 1'b1;
                    end else begin
                        n_status = pct_pkg::ST_NO_MATCH;
                    end
                    n_state = S_RESP;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (cmp.hit) begin
                    case (r_cmd)
                        pct_pkg::CMD_ADD: begin
                            mem_we  = 1'b1;
                            n_ok    = 1'b1;
                            n_state = S_RESP;
                        end
                        pct_pkg::CMD_REMOVE: begin
                            n_state = S_SHIFT_RD;
                        end
                        pct_pkg::CMD_VALIDATE: begin
                            if (cmp.window_fail) begin
                                n_status = pct_pkg::ST_WINDOW;
                            end else begin
                                n_ok = 1'b1;
                            end
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end else begin
                    n_ptr   = ptr_inc;
                    n_state = S_READ;
                end
            end
            S_SHIFT_RD: begin
                if (ptr_inc >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                    n_state = S_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_inc[AW-1:0];
                    n_state   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                // move entry ptr+1 down into slot ptr
                mem_we    = 1'b1;
                mem_wdata = r_rd_data;
                n_ptr     = ptr_inc;
                n_state   = S_SHIFT_RD;
            end
            S_RESP: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_ok     <= n_ok;
        r_status <= n_status;
    end

endmodule
